/* hw/rtl/uwc_pkg.sv */
// uwc_pkg: shared types and constants for the UTF-8 width converter.
// Used by uwc_front, uwc_queue, uwc_back and the top level; no dependencies.
package uwc_pkg;

   // hold states of the full-to-half decoder
   localparam logic [1:0] HOLD_NONE = 2'd0;
   localparam logic [1:0] HOLD_ONE  = 2'd1;
   localparam logic [1:0] HOLD_TWO  = 2'd2;

   // direction_mode codes
   localparam logic MODE_FULL_TO_HALF = 1'b0;
   localparam logic MODE_HALF_TO_FULL = 1'b1;

   // register map
   localparam logic REG_DIRECTION_MODE = 1'b0;

   // code points and byte ranges
   localparam logic [15:0] CP_IDEO_SPACE = 16'h3000;
   localparam logic [15:0] CP_FW_FIRST   = 16'hFF01;
   localparam logic [15:0] CP_FW_LAST    = 16'hFF5E;
   localparam logic [15:0] CP_FW_OFFSET  = 16'hFEE0;
   localparam logic [7:0]  BYTE_SPACE    = 8'h20;
   localparam logic [7:0]  BYTE_FIRST    = 8'h21;
   localparam logic [7:0]  BYTE_LAST     = 8'h7E;
   localparam logic [7:0]  LEAD3_BASE    = 8'hE0;
   localparam logic [7:0]  CONT_BASE     = 8'h80;
   localparam logic [3:0]  LEAD3_NIBBLE  = 4'hE;

   // job queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // one classified input: up to three output bytes
   typedef struct packed {
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] b2;
      logic [1:0] cnt;   // number of bytes, 1 to 3
      logic       eos;   // run closes the string
   } job_type;

   // front status seen by the top level
   typedef struct packed {
      logic [1:0] held_cnt;
   } front_status_type;

endpackage

/* hw/rtl/uwc_front.sv */
// uwc_front: accepts input bytes, tracks held sequence bytes, and turns each
// transfer that completes a run into a job of one to three output bytes. Depends on uwc_pkg.
module uwc_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      mode,
   input  logic                      cfg_clear,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,
   input  logic                      req_tlast,
   input  logic                      space,
   output logic                      job_push,
   output uwc_pkg::job_type          job,
   output uwc_pkg::front_status_type status
);

   logic [1:0]  held_cnt_ff, held_cnt_in;
   logic [7:0]  held_lead_ff, held_lead_in;
   logic [7:0]  held_second_ff, held_second_in;
   logic        fire;
   logic        gen;
   logic [15:0] cp_up;
   logic [15:0] cp_dn;
   logic [15:0] cp_half;

   assign req_tready = space;
   assign fire       = req_tvalid & space;

   assign cp_up   = {8'h00, req_tdata} + uwc_pkg::CP_FW_OFFSET;
   assign cp_dn   = {held_lead_ff[3:0], held_second_ff[5:0], req_tdata[5:0]};
   assign cp_half = cp_dn - uwc_pkg::CP_FW_OFFSET;

   always_comb begin
      held_cnt_in    = held_cnt_ff;
      held_lead_in   = held_lead_ff;
      held_second_in = held_second_ff;
      gen            = 1'b0;
      job            = '0;
      job.eos        = req_tlast;
      if (mode == uwc_pkg::MODE_HALF_TO_FULL) begin
         gen = 1'b1;
         if (req_tdata >= uwc_pkg::BYTE_FIRST && req_tdata <= uwc_pkg::BYTE_LAST) begin
            job.b0  = uwc_pkg::LEAD3_BASE | {4'h0, cp_up[15:12]};
            job.b1  = uwc_pkg::CONT_BASE | {2'b00, cp_up[11:6]};
            job.b2  = uwc_pkg::CONT_BASE | {2'b00, cp_up[5:0]};
            job.cnt = 2'd3;
         end else if (req_tdata == uwc_pkg::BYTE_SPACE) begin
            job.b0  = uwc_pkg::LEAD3_BASE | {4'h0, uwc_pkg::CP_IDEO_SPACE[15:12]};
            job.b1  = uwc_pkg::CONT_BASE | {2'b00, uwc_pkg::CP_IDEO_SPACE[11:6]};
            job.b2  = uwc_pkg::CONT_BASE | {2'b00, uwc_pkg::CP_IDEO_SPACE[5:0]};
            job.cnt = 2'd3;
         end else begin
            job.b0  = req_tdata;
            job.cnt = 2'd1;
         end
      end else begin
         unique case (held_cnt_ff)
            uwc_pkg::HOLD_NONE: begin
               if (req_tdata[7:4] == uwc_pkg::LEAD3_NIBBLE && !req_tlast) begin
                  held_lead_in = req_tdata;
                  held_cnt_in  = uwc_pkg::HOLD_ONE;
               end else begin
                  gen     = 1'b1;
                  job.b0  = req_tdata;
                  job.cnt = 2'd1;
               end
            end
            uwc_pkg::HOLD_ONE: begin
               if (req_tlast) begin
                  // string ends mid-sequence: flush what we have
                  gen         = 1'b1;
                  job.b0      = held_lead_ff;
                  job.b1      = req_tdata;
                  job.cnt     = 2'd2;
                  held_cnt_in = uwc_pkg::HOLD_NONE;
               end else begin
                  held_second_in = req_tdata;
                  held_cnt_in    = uwc_pkg::HOLD_TWO;
               end
            end
            default: begin
               gen         = 1'b1;
               held_cnt_in = uwc_pkg::HOLD_NONE;
               if (cp_dn == uwc_pkg::CP_IDEO_SPACE) begin
                  job.b0  = uwc_pkg::BYTE_SPACE;
                  job.cnt = 2'd1;
               end else if (cp_dn >= uwc_pkg::CP_FW_FIRST && cp_dn <= uwc_pkg::CP_FW_LAST) begin
                  job.b0  = cp_half[7:0];
                  job.cnt = 2'd1;
               end else begin
                  job.b0  = held_lead_ff;
                  job.b1  = held_second_ff;
                  job.b2  = req_tdata;
                  job.cnt = 2'd3;
               end
            end
         endcase
      end
   end

   assign job_push        = fire & gen;
   assign status.held_cnt = held_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_cnt_ff <= uwc_pkg::HOLD_NONE;
      end else if (cfg_clear) begin
         held_cnt_ff <= uwc_pkg::HOLD_NONE;
      end else if (fire) begin
         held_cnt_ff <= held_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         held_lead_ff   <= held_lead_in;
         held_second_ff <= held_second_in;
      end
   end

endmodule

/* hw/rtl/uwc_queue.sv */
// uwc_queue: short job queue that decouples front and back.
// Depends on uwc_pkg for the job type and depth.
module uwc_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  uwc_pkg::job_type push_job,
   output logic             space,
   input  logic             pop,
   output logic             avail,
   output uwc_pkg::job_type pop_job
);

   uwc_pkg::job_type                   slot_ff [uwc_pkg::QUEUE_DEPTH];
   logic [uwc_pkg::QUEUE_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [uwc_pkg::QUEUE_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [uwc_pkg::QUEUE_CNT_W-1:0]    count_ff, count_in;

   localparam logic [uwc_pkg::QUEUE_CNT_W-1:0] FULL_CNT =
      uwc_pkg::QUEUE_CNT_W'(uwc_pkg::QUEUE_DEPTH);
   localparam logic [uwc_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
      uwc_pkg::QUEUE_PTR_W'(uwc_pkg::QUEUE_DEPTH - 1);

   assign space   = (count_ff != FULL_CNT);
   assign avail   = (count_ff != '0);
   assign pop_job = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

/* hw/rtl/uwc_back.sv */
// uwc_back: holds the current job and sends its bytes one per transfer.
// Depends on uwc_pkg for the job type.
module uwc_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             avail,
   input  uwc_pkg::job_type next_job,
   output logic             pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_tdata,
   output logic             rsp_tlast,
   output logic             rsp_tuser
);

   uwc_pkg::job_type cur_ff;
   logic             valid_ff, valid_in;
   logic [1:0]       idx_ff, idx_in;
   logic             last;
   logic             fire;

   assign last = (idx_ff == (cur_ff.cnt - 2'd1));
   assign fire = valid_ff & rsp_tready;
   assign pop  = avail & (!valid_ff | (fire & last));

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (pop) begin
         valid_in = 1'b1;
         idx_in   = 2'd0;
      end else if (fire) begin
         if (last) begin
            valid_in = 1'b0;
            idx_in   = 2'd0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= next_job;
      end
   end

   always_comb begin
      case (idx_ff)
         2'd0:    rsp_tdata = cur_ff.b0;
         2'd1:    rsp_tdata = cur_ff.b1;
         default: rsp_tdata = cur_ff.b2;
      endcase
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = last;
   assign rsp_tlast  = last & cur_ff.eos;

endmodule

/* hw/rtl/utf8_width_converter_top.sv */
// utf8_width_converter_top: full-width / half-width conversion on a UTF-8
// byte stream, one byte per transfer on each side.
// The input transfer that completes a run writes a queue slot; the back-end
// output register then presents its first result byte. Throughput: one input
// per cycle while results are one byte each and rsp_tready is high; an input
// that expands to three bytes holds the result port for three transfers, so
// the single byte-wide result channel sets the rate. Held bytes yield nothing.
// Reset (synchronous, active high) clears mode, hold state, queue and output.
module utf8_width_converter_top (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] in_byte
   input  logic        req_tlast,    // end_of_string
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,    // [7:0] out_byte
   output logic        rsp_tlast,    // string_end
   output logic        rsp_tuser,    // [0] run_end
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic                      mode_ff;
   logic                      csr_write;
   logic                      cfg_clear;
   logic                      q_space;
   logic                      q_avail;
   logic                      q_pop;
   logic                      job_push;
   uwc_pkg::job_type          job;
   uwc_pkg::job_type          q_job;
   uwc_pkg::front_status_type front_status;

   // Register file: one register, word-addressed by paddr[2].
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign cfg_clear  = csr_write & (csr_paddr[2] == uwc_pkg::REG_DIRECTION_MODE);
   assign csr_prdata = (csr_paddr[2] == uwc_pkg::REG_DIRECTION_MODE) ?
                       {31'd0, mode_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= uwc_pkg::MODE_FULL_TO_HALF;
      end else if (cfg_clear) begin
         mode_ff <= csr_pwdata[0];
      end
   end

   // Front: classify bytes, track held sequence bytes (cleared on mode write).
   uwc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .mode       (mode_ff),
      .cfg_clear  (cfg_clear),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .space      (q_space),
      .job_push   (job_push),
      .job        (job),
      .status     (front_status)
   );

   // Queue: lets the front keep taking bytes while the back drains a run.
   uwc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (job),
      .space    (q_space),
      .pop      (q_pop),
      .avail    (q_avail),
      .pop_job  (q_job)
   );

   // Back: one byte per result transfer from the current job.
   uwc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .avail      (q_avail),
      .next_job   (q_job),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

`ifndef SYNTHESIS
   // every half-to-full input yields a job at once
   a_h2f_push: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && mode_ff == uwc_pkg::MODE_HALF_TO_FULL) |-> job_push)
      else $error("half-to-full transfer produced no job");

   // a job always carries at least one byte
   a_job_nonempty: assert property (@(posedge clock) disable iff (reset)
      job_push |-> (job.cnt != 2'd0))
      else $error("empty job pushed");

   // string end only on the last byte of a run
   a_end_is_run_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> rsp_tuser)
      else $error("string_end without run_end");

   // a mode write drops any held sequence bytes
   a_cfg_clears_hold: assert property (@(posedge clock) disable iff (reset)
      cfg_clear |=> (front_status.held_cnt == uwc_pkg::HOLD_NONE))
      else $error("hold not cleared after mode write");
`endif

endmodule
